// ----- design/crst_pkg.sv -----
package crst_pkg;

   // fixed field widths
   localparam int CoordWidth   = 16;
   localparam int CoefWidth    = CoordWidth + 4;
   localparam int ColorWidth   = 24;
   localparam int AlphaWidth   = 8;
   localparam int CountWidth   = 6;
   localparam int StepWidth    = 16;
   localparam int CsrDataWidth = 16;
   localparam int CsrIdxWidth  = 1;
   localparam int QueueDepth   = 2;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CsrSegmentCount = 1'b0;
   localparam logic [CsrIdxWidth-1:0] CsrStepFraction = 1'b1;

   // register reset values
   localparam logic [CountWidth-1:0] SegmentCountReset = 6'd20;
   localparam logic [StepWidth-1:0]  StepFractionReset = 16'd3277;

   typedef struct packed {
      logic signed [CoordWidth-1:0] p0_x;
      logic signed [CoordWidth-1:0] p0_y;
      logic signed [CoordWidth-1:0] p1_x;
      logic signed [CoordWidth-1:0] p1_y;
      logic signed [CoordWidth-1:0] p2_x;
      logic signed [CoordWidth-1:0] p2_y;
      logic signed [CoordWidth-1:0] p3_x;
      logic signed [CoordWidth-1:0] p3_y;
      logic [ColorWidth-1:0]        start_color;
      logic [ColorWidth-1:0]        end_color;
      logic [AlphaWidth-1:0]        start_alpha;
      logic [AlphaWidth-1:0]        end_alpha;
   } req_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] vertex_x;
      logic signed [CoordWidth-1:0] vertex_y;
      logic [ColorWidth-1:0]        vertex_color;
      logic [AlphaWidth-1:0]        vertex_alpha;
      logic                         last_vertex;
   } rsp_type;

   typedef struct packed {
      logic [CountWidth-1:0] segment_count;
      logic [StepWidth-1:0]  step_fraction;
   } cfg_type;

   // cubic coefficients of one axis, unscaled
   typedef struct packed {
      logic signed [CoefWidth-1:0] c0;
      logic signed [CoefWidth-1:0] c1;
      logic signed [CoefWidth-1:0] c2;
      logic signed [CoefWidth-1:0] c3;
   } coef_type;

   // one classified segment as it waits for the vertex engine
   typedef struct packed {
      coef_type              cx;
      coef_type              cy;
      logic [ColorWidth-1:0] start_color;
      logic [ColorWidth-1:0] end_color;
      logic [AlphaWidth-1:0] start_alpha;
      logic [AlphaWidth-1:0] end_alpha;
   } seg_type;

   // catmull-rom basis: 2p1, p2-p0, 2p0-5p1+4p2-p3, -p0+3p1-3p2+p3
   function automatic coef_type coef_calc(
      input logic signed [CoordWidth-1:0] q0,
      input logic signed [CoordWidth-1:0] q1,
      input logic signed [CoordWidth-1:0] q2,
      input logic signed [CoordWidth-1:0] q3
   );
      logic signed [CoefWidth-1:0] e0;
      logic signed [CoefWidth-1:0] e1;
      logic signed [CoefWidth-1:0] e2;
      logic signed [CoefWidth-1:0] e3;
      coef_type c;
      e0 = {{(CoefWidth-CoordWidth){q0[CoordWidth-1]}}, q0};
      e1 = {{(CoefWidth-CoordWidth){q1[CoordWidth-1]}}, q1};
      e2 = {{(CoefWidth-CoordWidth){q2[CoordWidth-1]}}, q2};
      e3 = {{(CoefWidth-CoordWidth){q3[CoordWidth-1]}}, q3};
      c.c0 = e1 <<< 1;
      c.c1 = e2 - e0;
      c.c2 = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      c.c3 = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
      return c;
   endfunction

endpackage

// ----- design/crst_seg_queue.sv -----
module crst_seg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  crst_pkg::seg_type push_data,
   output logic              full,
   input  logic              pop,
   output crst_pkg::seg_type pop_data,
   output logic              empty
);

   localparam int PtrWidth = $clog2(crst_pkg::QueueDepth);

   crst_pkg::seg_type   mem_ff [crst_pkg::QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrWidth:0]   count_ff, count_in;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PtrWidth+1)'(push) - (PtrWidth+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign full     = (count_ff == (PtrWidth+1)'(crst_pkg::QueueDepth));

endmodule

// ----- design/crst_front.sv -----
module crst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  crst_pkg::req_type req_data,
   output logic              seg_push,
   input  logic              seg_full,
   output crst_pkg::seg_type seg_data
);

   logic              item_v_ff, item_v_in;
   crst_pkg::req_type item_ff;
   logic              accept;

   // hold one transaction until the queue takes it
   assign req_full = item_v_ff && seg_full;
   assign accept   = req_push && !req_full;
   assign seg_push = item_v_ff && !seg_full;

   always_comb begin
      if (accept) begin
         item_v_in = 1'b1;
      end else if (seg_push) begin
         item_v_in = 1'b0;
      end else begin
         item_v_in = item_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_v_ff <= 1'b0;
      end else begin
         item_v_ff <= item_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   // turn control points into polynomial coefficients
   always_comb begin
      seg_data.cx = crst_pkg::coef_calc(item_ff.p0_x, item_ff.p1_x, item_ff.p2_x, item_ff.p3_x);
      seg_data.cy = crst_pkg::coef_calc(item_ff.p0_y, item_ff.p1_y, item_ff.p2_y, item_ff.p3_y);
      seg_data.start_color = item_ff.start_color;
      seg_data.end_color   = item_ff.end_color;
      seg_data.start_alpha = item_ff.start_alpha;
      seg_data.end_alpha   = item_ff.end_alpha;
   end

endmodule

// ----- design/crst_back.sv -----
module crst_back #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  crst_pkg::cfg_type cfg,
   input  logic              seg_empty,
   input  crst_pkg::seg_type seg_data,
   output logic              seg_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output crst_pkg::rsp_type rsp_data
);

   localparam int T      = T_FRAC_BITS;
   localparam int TW     = T + 1;
   localparam int RawW   = crst_pkg::CountWidth + crst_pkg::StepWidth;
   localparam int TXW    = RawW + T;
   localparam int SW     = crst_pkg::CoefWidth + T + 1;
   localparam int PW     = SW + TW + 1;
   localparam int LW     = 8 + TW;
   localparam int CW     = crst_pkg::CoordWidth;
   localparam int Stages = 9;
   localparam int Last   = Stages - 1;

   localparam logic [TW-1:0]        OneT    = TW'(1) << T;
   localparam logic [PW-1:0]        HalfP   = PW'(1) << (T - 1);
   localparam logic [LW-1:0]        HalfL   = LW'(1) << (T - 1);
   localparam logic [SW-1:0]        OneS    = SW'(1) << T;
   localparam logic signed [SW-1:0] CoordMax = SW'((1 << (CW - 1)) - 1);
   localparam logic signed [SW-1:0] CoordMin = -CoordMax - SW'(1);

   typedef struct packed {
      logic                   last;
      logic [RawW-1:0]        raw;
      logic [TW-1:0]          t;
      crst_pkg::seg_type      seg;
      logic signed [SW-1:0]   ax;
      logic signed [SW-1:0]   ay;
      logic signed [PW-1:0]   px;
      logic signed [PW-1:0]   py;
      logic [3:0][LW-1:0]     lsum;
      logic [3:0][7:0]        lres;
      logic signed [CW-1:0]   vx;
      logic signed [CW-1:0]   vy;
   } vtx_type;

   vtx_type pipe_ff [Stages];
   vtx_type pipe_in [Stages];
   logic [Stages-1:0] valid_ff;
   logic [crst_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic en;
   logic issue;
   logic issue_last;

   // product with t, rounded half away from zero
   function automatic logic signed [SW-1:0] rnd_t(input logic signed [PW-1:0] p);
      logic signed [PW-1:0] q;
      logic signed [PW-1:0] r;
      q = p + HalfP - {{(PW-1){1'b0}}, p[PW-1]};
      r = q >>> T;
      return r[SW-1:0];
   endfunction

   // coefficient scaled to the accumulator's fraction
   function automatic logic signed [SW-1:0] scale(
      input logic signed [crst_pkg::CoefWidth-1:0] c
   );
      return {{(SW-crst_pkg::CoefWidth-T){c[crst_pkg::CoefWidth-1]}}, c, {T{1'b0}}};
   endfunction

   // final halving, rounding and saturation
   function automatic logic signed [CW-1:0] fin(input logic signed [SW-1:0] s);
      logic signed [SW-1:0] q;
      logic signed [SW-1:0] r;
      q = s + OneS - {{(SW-1){1'b0}}, s[SW-1]};
      r = q >>> (T + 1);
      if (r > CoordMax) begin
         r = CoordMax;
      end else if (r < CoordMin) begin
         r = CoordMin;
      end
      return r[CW-1:0];
   endfunction

   // whole pipe moves unless the output holds an untaken vertex
   assign en         = !valid_ff[Last] || rsp_pop;
   assign issue      = en && !seg_empty;
   assign issue_last = (cnt_ff == cfg.segment_count);
   assign seg_pop    = issue && issue_last;
   assign cnt_in     = issue ? (issue_last ? '0 : cnt_ff + 1'b1) : cnt_ff;

   // per-stage work
   always_comb begin
      logic [TXW-1:0] tw;
      logic [7:0]     a;
      logic [7:0]     b;
      for (int k = 1; k < Stages; k++) begin
         pipe_in[k] = pipe_ff[k-1];
      end
      pipe_in[0]      = pipe_ff[0];
      pipe_in[0].last = issue_last;
      pipe_in[0].raw  = RawW'(cnt_ff) * RawW'(cfg.step_fraction);
      pipe_in[0].seg  = seg_data;

      // parameter t, truncated then clamped to one
      tw = {pipe_ff[0].raw, {T{1'b0}}} >> 16;
      pipe_in[1].t = (tw > TXW'(OneT)) ? OneT : tw[TW-1:0];

      // c3*t is exact; linear blend sums
      pipe_in[2].px = PW'(pipe_ff[1].seg.cx.c3) * PW'($signed({1'b0, pipe_ff[1].t}));
      pipe_in[2].py = PW'(pipe_ff[1].seg.cy.c3) * PW'($signed({1'b0, pipe_ff[1].t}));
      for (int j = 0; j < 4; j++) begin
         if (j < 3) begin
            a = pipe_ff[1].seg.start_color[8*j +: 8];
            b = pipe_ff[1].seg.end_color[8*j +: 8];
         end else begin
            a = pipe_ff[1].seg.start_alpha;
            b = pipe_ff[1].seg.end_alpha;
         end
         pipe_in[2].lsum[j] = LW'(a) * LW'(OneT - pipe_ff[1].t) + LW'(b) * LW'(pipe_ff[1].t);
      end

      // horner step one
      pipe_in[3].ax = pipe_ff[2].px[SW-1:0] + scale(pipe_ff[2].seg.cx.c2);
      pipe_in[3].ay = pipe_ff[2].py[SW-1:0] + scale(pipe_ff[2].seg.cy.c2);
      for (int j = 0; j < 4; j++) begin
         pipe_in[3].lres[j] = 8'((pipe_ff[2].lsum[j] + HalfL) >> T);
      end

      // horner step two
      pipe_in[4].px = PW'(pipe_ff[3].ax) * PW'($signed({1'b0, pipe_ff[3].t}));
      pipe_in[4].py = PW'(pipe_ff[3].ay) * PW'($signed({1'b0, pipe_ff[3].t}));
      pipe_in[5].ax = rnd_t(pipe_ff[4].px) + scale(pipe_ff[4].seg.cx.c1);
      pipe_in[5].ay = rnd_t(pipe_ff[4].py) + scale(pipe_ff[4].seg.cy.c1);

      // horner step three
      pipe_in[6].px = PW'(pipe_ff[5].ax) * PW'($signed({1'b0, pipe_ff[5].t}));
      pipe_in[6].py = PW'(pipe_ff[5].ay) * PW'($signed({1'b0, pipe_ff[5].t}));
      pipe_in[7].ax = rnd_t(pipe_ff[6].px) + scale(pipe_ff[6].seg.cx.c0);
      pipe_in[7].ay = rnd_t(pipe_ff[6].py) + scale(pipe_ff[6].seg.cy.c0);

      // output register
      pipe_in[8].vx = fin(pipe_ff[7].ax);
      pipe_in[8].vy = fin(pipe_ff[7].ay);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (en) begin
            valid_ff <= {valid_ff[Stages-2:0], issue};
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < Stages; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_empty             = !valid_ff[Last];
   assign rsp_data.vertex_x     = pipe_ff[Last].vx;
   assign rsp_data.vertex_y     = pipe_ff[Last].vy;
   assign rsp_data.vertex_color = {pipe_ff[Last].lres[2], pipe_ff[Last].lres[1],
                                   pipe_ff[Last].lres[0]};
   assign rsp_data.vertex_alpha = pipe_ff[Last].lres[3];
   assign rsp_data.last_vertex  = pipe_ff[Last].last;

endmodule

// ----- design/catmull_rom_segment_tessellator.sv -----
// channel    | ports                          | moves
// -----------+--------------------------------+--------------------------------
// request    | req_push, req_full, req_data   | one segment per transaction
// response   | rsp_empty, rsp_pop, rsp_data   | one vertex per transaction
// csr        | csr_wr_en, csr_index, csr_wdata| register write, no wait
//
// a segment yields segment_count+1 vertices, one per cycle from the vertex
// counter in the back end while the evaluation pipe is not stalled. the first
// vertex passes the front register, the queue and the 9-stage evaluation pipe.
// a 2-entry queue lets requests land while the back end works. a full output
// stalls the whole evaluation pipe.
// synchronous active-high reset clears control state; no clearing pass.
module catmull_rom_segment_tessellator #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  crst_pkg::req_type                    req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output crst_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [crst_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [crst_pkg::CsrDataWidth-1:0]    csr_wdata
);

   crst_pkg::cfg_type cfg_ff, cfg_in;
   crst_pkg::seg_type front_seg;
   crst_pkg::seg_type queue_seg;
   logic              seg_push;
   logic              seg_full;
   logic              seg_pop;
   logic              seg_empty;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            crst_pkg::CsrSegmentCount: begin
               cfg_in.segment_count = csr_wdata[crst_pkg::CountWidth-1:0];
            end
            crst_pkg::CsrStepFraction: begin
               cfg_in.step_fraction = csr_wdata[crst_pkg::StepWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.segment_count <= crst_pkg::SegmentCountReset;
         cfg_ff.step_fraction <= crst_pkg::StepFractionReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // request side
   crst_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .seg_push (seg_push),
      .seg_full (seg_full),
      .seg_data (front_seg)
   );

   // segment queue between front and back
   crst_seg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (seg_push),
      .push_data (front_seg),
      .full      (seg_full),
      .pop       (seg_pop),
      .pop_data  (queue_seg),
      .empty     (seg_empty)
   );

   // vertex engine
   crst_back #(
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .seg_empty (seg_empty),
      .seg_data  (queue_seg),
      .seg_pop   (seg_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/crst_vertex_checker.sv -----
module crst_vertex_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   input  logic                                 req_full,
   input  crst_pkg::req_type                    req_data,
   input  logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   input  crst_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [crst_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [crst_pkg::CsrDataWidth-1:0]    csr_wdata,
   output int                                   fail_count,
   output int                                   pending,
   output int                                   vertex_count
);
   import crst_pkg::*;

   localparam longint TOne  = 64'd65536;
   localparam longint THalf = 64'd32768;

   logic [CountWidth-1:0] seg_count_q;
   logic [StepWidth-1:0]  step_q;
   rsp_type               vertex_queue[$];

   // product with t, rounded half away from zero
   function automatic longint scale_by_t(longint s, longint t);
      longint m;
      m = (s < 0) ? -s : s;
      m = (m * t + THalf) >>> 16;
      return (s < 0) ? -m : m;
   endfunction

   // one axis of the cubic, horner form, halved and saturated
   function automatic logic signed [CoordWidth-1:0] curve_axis(
      longint q0, longint q1, longint q2, longint q3, longint t);
      longint acc;
      longint m;
      longint v;
      acc = (-q0 + 3 * q1 - 3 * q2 + q3) * TOne;
      acc = scale_by_t(acc, t) + (2 * q0 - 5 * q1 + 4 * q2 - q3) * TOne;
      acc = scale_by_t(acc, t) + (q2 - q0) * TOne;
      acc = scale_by_t(acc, t) + 2 * q1 * TOne;
      m = (acc < 0) ? -acc : acc;
      m = (m + TOne) >>> 17;
      v = (acc < 0) ? -m : m;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[CoordWidth-1:0];
   endfunction

   function automatic logic [7:0] blend_byte(longint a, longint b, longint t);
      longint r;
      r = (a * (TOne - t) + b * t + THalf) >>> 16;
      return r[7:0];
   endfunction

   // expand one segment into its vertices
   task automatic tessellate(input req_type seg);
      rsp_type v;
      longint  t;
      for (int i = 0; i <= seg_count_q; i++) begin
         t = longint'(i) * longint'(step_q);
         if (t > TOne) t = TOne;
         v.vertex_x = curve_axis(seg.p0_x, seg.p1_x, seg.p2_x, seg.p3_x, t);
         v.vertex_y = curve_axis(seg.p0_y, seg.p1_y, seg.p2_y, seg.p3_y, t);
         for (int ch = 0; ch < 3; ch++)
            v.vertex_color[8*ch +: 8] = blend_byte(seg.start_color[8*ch +: 8],
                                                   seg.end_color[8*ch +: 8], t);
         v.vertex_alpha = blend_byte(seg.start_alpha, seg.end_alpha, t);
         v.last_vertex  = (i == seg_count_q);
         vertex_queue = {vertex_queue, v};
      end
   endtask

   assign pending = vertex_queue.size();

   // watch csr writes, request and response transactions
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         seg_count_q  <= SegmentCountReset;
         step_q       <= StepFractionReset;
         fail_count   <= 0;
         vertex_count <= 0;
         vertex_queue.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CsrSegmentCount) seg_count_q <= csr_wdata[CountWidth-1:0];
            else if (csr_index == CsrStepFraction) step_q <= csr_wdata[StepWidth-1:0];
         end
         if (rsp_pop && !rsp_empty) begin
            vertex_count <= vertex_count + 1;
            if (vertex_queue.size() == 0) begin
               $error("vertex with none expected: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = vertex_queue.pop_front();
               if (e != rsp_data) begin
                  if (e.vertex_x != rsp_data.vertex_x)
                     $error("vertex_x expected %0d actual %0d", e.vertex_x, rsp_data.vertex_x);
                  if (e.vertex_y != rsp_data.vertex_y)
                     $error("vertex_y expected %0d actual %0d", e.vertex_y, rsp_data.vertex_y);
                  if (e.vertex_color != rsp_data.vertex_color)
                     $error("vertex_color expected %h actual %h",
                            e.vertex_color, rsp_data.vertex_color);
                  if (e.vertex_alpha != rsp_data.vertex_alpha)
                     $error("vertex_alpha expected %0d actual %0d",
                            e.vertex_alpha, rsp_data.vertex_alpha);
                  if (e.last_vertex != rsp_data.last_vertex)
                     $error("last_vertex expected %0d actual %0d",
                            e.last_vertex, rsp_data.last_vertex);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_push && !req_full) tessellate(req_data);
      end
   end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
   import crst_pkg::*;

   localparam int CycleLimit = 2000000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    csr_wr_en = 1'b0;
   logic [CsrIdxWidth-1:0]  csr_index = CsrSegmentCount;
   logic [CsrDataWidth-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int vertex_count;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int segments_sent = 0;

   catmull_rom_segment_tessellator u_dut (
      .clock, .reset, .req_push, .req_full, .req_data,
      .rsp_empty, .rsp_pop, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata);

   crst_vertex_checker u_checker (
      .clock, .reset, .req_push, .req_full, .req_data,
      .rsp_empty, .rsp_pop, .rsp_data, .csr_wr_en, .csr_index, .csr_wdata,
      .fail_count, .pending, .vertex_count);

   initial begin
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // response side stalls at random
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
   end

   // stop sending, wait for the block to drain, then let the pipe settle
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // one request transaction, then, at random, a random gap
   task automatic send_segment(input req_type seg);
      req_push <= 1'b1;
      req_data <= seg;
      @(posedge clock);
      while (req_full) @(posedge clock);
      segments_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic req_type uniform_segment(input logic [15:0] c, input logic [23:0] col,
                                               input logic [7:0] al);
      req_type s;
      s = {{8{c}}, col, col, al, al};
      return s;
   endfunction

   // random segment, mostly full range, some near one spot
   function automatic req_type random_segment();
      req_type     s;
      logic [15:0] base;
      s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(3) == 0) begin
         base = 16'($urandom);
         s.p0_x = 16'(base + $urandom_range(0, 1023) - 512);
         s.p1_x = 16'(base + $urandom_range(0, 1023) - 512);
         s.p2_x = 16'(base + $urandom_range(0, 1023) - 512);
         s.p3_x = 16'(base + $urandom_range(0, 1023) - 512);
         s.p0_y = 16'(base - $urandom_range(0, 255));
         s.p1_y = 16'(base + $urandom_range(0, 255));
         s.p2_y = 16'(base - $urandom_range(0, 255));
         s.p3_y = 16'(base + $urandom_range(0, 255));
      end
      return s;
   endfunction

   task automatic random_config();
      int n;
      n = ($urandom_range(4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 24);
      write_csr(CsrSegmentCount, 16'(n));
      case ($urandom_range(3))
         0: write_csr(CsrStepFraction, 16'($urandom));
         1: write_csr(CsrStepFraction, 16'($urandom_range(0, 8)));
         default: write_csr(CsrStepFraction, (n == 0) ? 16'hFFFF : 16'(65536 / n));
      endcase
   endtask

   initial begin
      req_type s;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes under reset registers
      send_segment(uniform_segment(16'h7FFF, 24'hFFFFFF, 8'hFF));
      send_segment(uniform_segment(16'h8000, 24'h000000, 8'h00));
      send_segment(uniform_segment(16'h0000, 24'h00FF00, 8'h80));
      s = {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
           24'h000000, 24'hFFFFFF, 8'h00, 8'hFF};
      send_segment(s);
      s = {16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
           24'hFFFFFF, 24'h000000, 8'hFF, 8'h00};
      send_segment(s);
      send_segment(random_segment());

      // zero subdivisions: single vertex
      write_csr(CsrSegmentCount, 16'd0);
      send_segment(s);
      send_segment(random_segment());
      // zero step: every vertex at the start
      write_csr(CsrSegmentCount, 16'd4);
      write_csr(CsrStepFraction, 16'd0);
      send_segment(s);
      send_segment(random_segment());
      // parameter past the end clamps
      write_csr(CsrSegmentCount, 16'd63);
      write_csr(CsrStepFraction, 16'hFFFF);
      send_segment(s);
      send_segment(random_segment());
      write_csr(CsrStepFraction, 16'd1);
      send_segment(random_segment());
      // upper bits of the count are masked off
      write_csr(CsrSegmentCount, 16'hFFC2);
      write_csr(CsrStepFraction, 16'h8000);
      send_segment(s);
      send_segment(random_segment());

      // random phases: no idling, sender idle, receiver stall, both
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = (ph == 1) ? 55 : (ph == 3) ? 15 : 0;
         recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 15 : 0;
         for (int k = 0; k < 3; k++) begin
            random_config();
            for (int j = 0; j < 26; j++) begin
               send_segment(random_segment());
               // hold off until every vertex is out
               if (j == 13 && k == 1) begin
                  drain();
               end
            end
         end
      end

      drain();
      repeat (30) @(posedge clock);
      $display("covered %0d segments, %0d vertices checked, over several register settings",
               segments_sent, vertex_count);
      $display("idle and stall mixes on both channels, zero count, zero step and clamped t");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
